// ----- hdl/vmd_pkg.sv -----
`default_nettype none

package vmd_pkg;

    localparam int BATCH_SAMPLES_DEFAULT = 8;
    localparam int OP_QUEUE_DEPTH_DEFAULT = 4;
    localparam int RES_QUEUE_DEPTH_DEFAULT = 4;

    // Wide enough for the batch sum at the largest supported batch of sixteen.
    localparam int OP_SUM_W = 14;

    localparam int SAMPLE_W = 10;
    localparam int VOLT_W = 6;

    localparam logic [2:0] LAST_BEAT = 3'd5;

    localparam logic OUT_DISPLAY = 1'b0;
    localparam logic OUT_SERIAL = 1'b1;

    localparam logic [1:0] DIGIT_EN_UNITS = 2'b01;
    localparam logic [1:0] DIGIT_EN_TENS = 2'b10;

    localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
    localparam logic [7:0] CHAR_LOWER_M = 8'h6D;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_LOWER_I = 8'h69;
    localparam logic [7:0] CHAR_LOWER_N = 8'h6E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_V = 8'h56;

    localparam logic [7:0] MIN_BCD_RESET = 8'hFF;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_RX     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_BATCH,
        OP_TICK_LOW,
        OP_TICK_HIGH,
        OP_REPORT_MAX,
        OP_REPORT_MIN
    } op_code_t;

    typedef logic [OP_SUM_W-1:0] op_sum_t;

    typedef struct packed {
        op_code_t code;
        op_sum_t  sum;
    } op_t;

    typedef struct packed {
        logic       out_kind;
        logic [6:0] segments;
        logic [1:0] digit_enable;
        logic [7:0] tx_byte;
        logic       last;
    } res_t;

    function automatic logic [6:0] seg_of(input logic [3:0] nib);
        logic [6:0] seg;
        case (nib)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7C;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h67;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // The voltage never exceeds 33, so the tens digit is at most 3.
    function automatic logic [7:0] to_bcd(input logic [VOLT_W-1:0] v);
        logic [1:0]        tens;
        logic [VOLT_W-1:0] ones;
        if (v >= VOLT_W'(30))
        begin
            tens = 2'd3;
            ones = v - VOLT_W'(30);
        end
        else if (v >= VOLT_W'(20))
        begin
            tens = 2'd2;
            ones = v - VOLT_W'(20);
        end
        else if (v >= VOLT_W'(10))
        begin
            tens = 2'd1;
            ones = v - VOLT_W'(10);
        end
        else
        begin
            tens = 2'd0;
            ones = v;
        end
        return {2'b00, tens, ones[3:0]};
    endfunction

    function automatic logic [7:0] report_byte(input logic is_max, input logic [2:0] beat,
                                               input logic [7:0] value);
        logic [7:0] b;
        case (beat)
            3'd0: b = is_max ? CHAR_UPPER_M : CHAR_LOWER_M;
            3'd1: b = is_max ? CHAR_LOWER_A : CHAR_LOWER_I;
            3'd2: b = is_max ? CHAR_LOWER_X : CHAR_LOWER_N;
            3'd3: b = CHAR_COLON;
            3'd4: b = value;
            default: b = CHAR_UPPER_V;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/vmd_fifo.sv -----
`default_nettype none

module vmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/vmd_front.sv -----
`default_nettype none

module vmd_front #(
    parameter int BATCH_SAMPLES = vmd_pkg::BATCH_SAMPLES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [1:0]                    kind,
    input  wire logic [vmd_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [7:0]                    rx_byte,
    input  wire logic                          op_full,
    output logic                               op_push,
    output vmd_pkg::op_t                       op
);

    localparam int SUM_W = $clog2(1023 * BATCH_SAMPLES + 1);
    localparam int CNT_W = (BATCH_SAMPLES > 1) ? $clog2(BATCH_SAMPLES) : 1;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             phase_reg, phase_next;
    logic [SUM_W-1:0] sum_total;
    logic             accept;

    assign accept = push && !op_full;
    assign sum_total = sum_reg + SUM_W'(sample);

    always_comb
    begin
        sum_next = sum_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        op_push = 1'b0;
        op.code = vmd_pkg::OP_BATCH;
        op.sum = vmd_pkg::op_sum_t'(sum_total);
        if (accept)
        begin
            unique case (vmd_pkg::kind_t'(kind))
                vmd_pkg::KIND_SAMPLE:
                begin
                    if (count_reg == CNT_W'(BATCH_SAMPLES - 1))
                    begin
                        op_push = 1'b1;
                        sum_next = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        sum_next = sum_total;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                vmd_pkg::KIND_TICK:
                begin
                    op_push = 1'b1;
                    op.code = phase_reg ? vmd_pkg::OP_TICK_HIGH : vmd_pkg::OP_TICK_LOW;
                    phase_next = !phase_reg;
                end
                vmd_pkg::KIND_RX:
                begin
                    if (rx_byte == vmd_pkg::CHAR_UPPER_M)
                    begin
                        op_push = 1'b1;
                        op.code = vmd_pkg::OP_REPORT_MAX;
                    end
                    else if (rx_byte == vmd_pkg::CHAR_LOWER_M)
                    begin
                        op_push = 1'b1;
                        op.code = vmd_pkg::OP_REPORT_MIN;
                    end
                end
                default:
                begin
                    op_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            count_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/vmd_back.sv -----
`default_nettype none

module vmd_back #(
    parameter int BATCH_SAMPLES = vmd_pkg::BATCH_SAMPLES_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    input  wire vmd_pkg::op_t  op,
    output logic               op_pop,
    input  wire logic          res_full,
    output logic               res_push,
    output vmd_pkg::res_t      res
);

    // The divide by 1023 * BATCH_SAMPLES is a multiply by a rounded-up reciprocal,
    // exact for every reachable numerator. Scale and offset fold into two constants.
    localparam longint unsigned DIVISOR = 1023 * BATCH_SAMPLES;
    localparam int DIV_W = $clog2(DIVISOR + 1);
    localparam int NUM_W = $clog2(34270 * BATCH_SAMPLES + 1);
    localparam int SHIFT = NUM_W + DIV_W;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PW = SHIFT + vmd_pkg::VOLT_W;
    localparam logic [PW-1:0] MUL_K = PW'(33 * RECIP);
    localparam logic [PW-1:0] ADD_K = PW'(511 * BATCH_SAMPLES * RECIP);

    logic               s1_valid_reg, s1_valid_next;
    vmd_pkg::op_code_t  s1_code_reg;
    logic [PW-1:0]      s1_prod_reg;
    logic [2:0]         beat_reg, beat_next;
    logic [7:0]         voltage_bcd_reg, voltage_bcd_next;
    logic [7:0]         min_bcd_reg, min_bcd_next;
    logic [7:0]         max_bcd_reg, max_bcd_next;

    logic               exe_fire;
    logic               is_report;
    logic               s1_done;
    logic               s1_ready;
    logic [7:0]         batch_bcd;

    assign exe_fire = s1_valid_reg && !res_full;
    assign is_report = (s1_code_reg == vmd_pkg::OP_REPORT_MAX)
                    || (s1_code_reg == vmd_pkg::OP_REPORT_MIN);
    assign s1_done = exe_fire && (!is_report || (beat_reg == vmd_pkg::LAST_BEAT));
    assign s1_ready = !s1_valid_reg || s1_done;
    assign op_pop = op_valid && s1_ready;
    assign batch_bcd = vmd_pkg::to_bcd(s1_prod_reg[PW-1:SHIFT]);

    always_comb
    begin
        res_push = exe_fire;
        res.out_kind = vmd_pkg::OUT_SERIAL;
        res.segments = '0;
        res.digit_enable = '0;
        res.tx_byte = '0;
        res.last = 1'b1;
        voltage_bcd_next = voltage_bcd_reg;
        min_bcd_next = min_bcd_reg;
        max_bcd_next = max_bcd_reg;
        beat_next = beat_reg;
        unique case (s1_code_reg) inside
            vmd_pkg::OP_BATCH:
            begin
                res.tx_byte = batch_bcd;
                if (exe_fire)
                begin
                    voltage_bcd_next = batch_bcd;
                    if (batch_bcd < min_bcd_reg)
                    begin
                        min_bcd_next = batch_bcd;
                    end
                    if (batch_bcd > max_bcd_reg)
                    begin
                        max_bcd_next = batch_bcd;
                    end
                end
            end
            vmd_pkg::OP_TICK_LOW:
            begin
                res.out_kind = vmd_pkg::OUT_DISPLAY;
                res.segments = vmd_pkg::seg_of(voltage_bcd_reg[3:0]);
                res.digit_enable = vmd_pkg::DIGIT_EN_UNITS;
            end
            vmd_pkg::OP_TICK_HIGH:
            begin
                res.out_kind = vmd_pkg::OUT_DISPLAY;
                res.segments = vmd_pkg::seg_of(voltage_bcd_reg[7:4]);
                res.digit_enable = vmd_pkg::DIGIT_EN_TENS;
            end
            vmd_pkg::OP_REPORT_MAX,
            vmd_pkg::OP_REPORT_MIN:
            begin
                res.tx_byte = vmd_pkg::report_byte(s1_code_reg == vmd_pkg::OP_REPORT_MAX,
                                                   beat_reg,
                                                   (s1_code_reg == vmd_pkg::OP_REPORT_MAX)
                                                       ? max_bcd_reg : min_bcd_reg);
                res.last = (beat_reg == vmd_pkg::LAST_BEAT);
                if (exe_fire)
                begin
                    beat_next = (beat_reg == vmd_pkg::LAST_BEAT) ? 3'd0 : beat_reg + 3'd1;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = op_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            beat_reg <= 3'd0;
            voltage_bcd_reg <= 8'h00;
            min_bcd_reg <= vmd_pkg::MIN_BCD_RESET;
            max_bcd_reg <= 8'h00;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            beat_reg <= beat_next;
            voltage_bcd_reg <= voltage_bcd_next;
            min_bcd_reg <= min_bcd_next;
            max_bcd_reg <= max_bcd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            s1_code_reg <= op.code;
            s1_prod_reg <= PW'(op.sum) * MUL_K + ADD_K;
        end
    end

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= vmd_pkg::LAST_BEAT)
        else $error("Report beat counter out of range.");

    a_beat_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_reg != 3'd0) |-> (s1_valid_reg && is_report))
        else $error("Report in progress without a report operation held.");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (exe_fire && s1_code_reg == vmd_pkg::OP_BATCH) |=> (min_bcd_reg <= max_bcd_reg))
        else $error("Minimum exceeds maximum after a batch.");

    a_voltage_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (voltage_bcd_reg[3:0] <= 4'd9) && (voltage_bcd_reg[7:4] <= 4'd3))
        else $error("Stored voltage is not a reachable BCD value.");

endmodule

`default_nettype wire

// ----- hdl/voltmeter_min_max_display_core.sv -----
`default_nettype none

// Channel   Handshake           Fields
// input     push / full         kind, sample, rx_byte
// result    empty / pop         out_kind, segments, digit_enable, tx_byte, last
//
// One input transaction is taken per cycle while the operation queue is not full; a
// result passes the operation queue, back-end stage and result queue. A report holds
// the back end for its six bytes; the operation queue takes transactions until full.
// Reset clears the batch sum, the stored voltage, the maximum and the display phase
// and sets the minimum to all ones. Full rises only when the operation queue is full.

module voltmeter_min_max_display_core #(
    parameter int BATCH_SAMPLES = vmd_pkg::BATCH_SAMPLES_DEFAULT,
    parameter int OP_QUEUE_DEPTH = vmd_pkg::OP_QUEUE_DEPTH_DEFAULT,
    parameter int RES_QUEUE_DEPTH = vmd_pkg::RES_QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [1:0]                    kind,
    input  wire logic [vmd_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [7:0]                    rx_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               out_kind,
    output logic [6:0]                         segments,
    output logic [1:0]                         digit_enable,
    output logic [7:0]                         tx_byte,
    output logic                               last
);

    vmd_pkg::op_t  fe_op;
    vmd_pkg::op_t  q_op;
    vmd_pkg::res_t be_res;
    vmd_pkg::res_t q_res;
    logic          fe_push;
    logic          op_full;
    logic          op_empty;
    logic          op_pop;
    logic          res_push;
    logic          res_full;

    assign full = op_full;

    vmd_front #(
        .BATCH_SAMPLES(BATCH_SAMPLES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .kind(kind),
        .sample(sample),
        .rx_byte(rx_byte),
        .op_full(op_full),
        .op_push(fe_push),
        .op(fe_op)
    );

    vmd_fifo #(
        .WIDTH($bits(vmd_pkg::op_t)),
        .DEPTH(OP_QUEUE_DEPTH)
    ) u_op_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(fe_push),
        .wr_data(fe_op),
        .full(op_full),
        .pop(op_pop),
        .rd_data(q_op),
        .empty(op_empty)
    );

    vmd_back #(
        .BATCH_SAMPLES(BATCH_SAMPLES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .op_valid(!op_empty),
        .op(q_op),
        .op_pop(op_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res(be_res)
    );

    vmd_fifo #(
        .WIDTH($bits(vmd_pkg::res_t)),
        .DEPTH(RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_push),
        .wr_data(be_res),
        .full(res_full),
        .pop(pop),
        .rd_data(q_res),
        .empty(empty)
    );

    assign out_kind = q_res.out_kind;
    assign segments = q_res.segments;
    assign digit_enable = q_res.digit_enable;
    assign tx_byte = q_res.tx_byte;
    assign last = q_res.last;

endmodule

`default_nettype wire

// ----- tb/voltmeter_min_max_display_core_tb.sv -----
`timescale 1ns / 1ps

module voltmeter_min_max_display_core_tb;

    localparam logic [1:0] KIND_IGNORED = 2'd3;
    localparam int SAMPLE_BITS = vmd_pkg::SAMPLE_W;
    localparam int BATCH = vmd_pkg::BATCH_SAMPLES_DEFAULT;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED = 40;
    localparam logic [69:0] DIGIT_SEGS = {7'h67, 7'h7F, 7'h07, 7'h7C, 7'h6D,
                                          7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    typedef struct {
        logic [1:0]             kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic [7:0]             rx_byte;
    } meter_input_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [1:0]             kind = '0;
    logic [SAMPLE_BITS-1:0] sample = '0;
    logic [7:0]             rx_byte = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   out_kind;
    logic [6:0]             segments;
    logic [1:0]             digit_enable;
    logic [7:0]             tx_byte;
    logic                   last;

    meter_input_t           pending_inputs[$];
    vmd_pkg::res_t          readings_due[$];
    vmd_pkg::res_t          next_due;

    logic [vmd_pkg::OP_SUM_W-1:0] batch_sum;
    int                     batch_count;
    logic [7:0]             volts_bcd;
    logic [7:0]             lowest_bcd;
    logic [7:0]             highest_bcd;
    logic                   showing_high;

    int                     send_idle_pct;
    int                     recv_stall_pct;
    int                     mismatches;
    int                     gen_samples;
    int                     gen_level;
    int                     phase;

    voltmeter_min_max_display_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .kind(kind),
        .sample(sample),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .out_kind(out_kind),
        .segments(segments),
        .digit_enable(digit_enable),
        .tx_byte(tx_byte),
        .last(last)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic queue_serial(input logic [7:0] b, input logic fin);
        vmd_pkg::res_t r;
        r.out_kind = vmd_pkg::OUT_SERIAL;
        r.segments = '0;
        r.digit_enable = '0;
        r.tx_byte = b;
        r.last = fin;
        readings_due.push_back(r);
    endtask

    task automatic meter_step(input logic [1:0] k, input logic [SAMPLE_BITS-1:0] s,
                              input logic [7:0] c);
        int            v;
        logic [3:0]    nib;
        logic          hi;
        vmd_pkg::res_t r;
        if (k == vmd_pkg::KIND_SAMPLE)
        begin
            batch_sum = batch_sum + s;
            batch_count++;
            if (batch_count == BATCH)
            begin
                v = (int'(batch_sum) * 33 + 511 * BATCH) / (1023 * BATCH);
                if (v > 99)
                    v = 99;
                volts_bcd = 8'((v / 10) * 16 + v % 10);
                if (volts_bcd < lowest_bcd)
                    lowest_bcd = volts_bcd;
                if (volts_bcd > highest_bcd)
                    highest_bcd = volts_bcd;
                batch_sum = '0;
                batch_count = 0;
                queue_serial(volts_bcd, 1'b1);
            end
        end
        else if (k == vmd_pkg::KIND_TICK)
        begin
            nib = showing_high ? volts_bcd[7:4] : volts_bcd[3:0];
            r.out_kind = vmd_pkg::OUT_DISPLAY;
            r.segments = (nib > 4'd9) ? 7'd0 : DIGIT_SEGS[nib * 7 +: 7];
            r.digit_enable = showing_high ? vmd_pkg::DIGIT_EN_TENS : vmd_pkg::DIGIT_EN_UNITS;
            r.tx_byte = '0;
            r.last = 1'b1;
            readings_due.push_back(r);
            showing_high = ~showing_high;
        end
        else if (k == vmd_pkg::KIND_RX &&
                 (c == vmd_pkg::CHAR_UPPER_M || c == vmd_pkg::CHAR_LOWER_M))
        begin
            hi = (c == vmd_pkg::CHAR_UPPER_M);
            queue_serial(c, 1'b0);
            queue_serial(hi ? vmd_pkg::CHAR_LOWER_A : vmd_pkg::CHAR_LOWER_I, 1'b0);
            queue_serial(hi ? vmd_pkg::CHAR_LOWER_X : vmd_pkg::CHAR_LOWER_N, 1'b0);
            queue_serial(vmd_pkg::CHAR_COLON, 1'b0);
            queue_serial(hi ? highest_bcd : lowest_bcd, 1'b0);
            queue_serial(vmd_pkg::CHAR_UPPER_V, 1'b1);
        end
    endtask

    task automatic add_input(input logic [1:0] k, input logic [SAMPLE_BITS-1:0] s,
                             input logic [7:0] c);
        meter_input_t it;
        it.kind = k;
        it.sample = s;
        it.rx_byte = c;
        pending_inputs.push_back(it);
    endtask

    task automatic add_random_inputs(input int count);
        int                     made;
        int                     pick;
        int                     lvl;
        logic [SAMPLE_BITS-1:0] s;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // Each batch clusters round its own level so that every voltage is reached.
                if (gen_samples % BATCH == 0)
                    gen_level = $urandom_range(1023);
                gen_samples++;
                case ($urandom_range(9))
                    0: s = SAMPLE_BITS'($urandom_range(1023));
                    1: s = $urandom_range(1) ? 10'd1023 : 10'd0;
                    default:
                    begin
                        lvl = gen_level + int'($urandom_range(40)) - 20;
                        if (lvl < 0)
                            lvl = 0;
                        if (lvl > 1023)
                            lvl = 1023;
                        s = SAMPLE_BITS'(lvl);
                    end
                endcase
                add_input(vmd_pkg::KIND_SAMPLE, s, 8'($urandom_range(255)));
                made++;
            end
            else if (pick < 75)
            begin
                add_input(vmd_pkg::KIND_TICK, SAMPLE_BITS'($urandom), 8'($urandom));
                made++;
            end
            else if (pick < 93)
            begin
                add_input(vmd_pkg::KIND_RX, SAMPLE_BITS'($urandom),
                          $urandom_range(1) ? vmd_pkg::CHAR_UPPER_M : vmd_pkg::CHAR_LOWER_M);
                made++;
            end
            else if (pick < 97)
                add_input(vmd_pkg::KIND_RX, SAMPLE_BITS'($urandom), 8'($urandom_range(255)));
            else
                add_input(KIND_IGNORED, SAMPLE_BITS'($urandom), 8'($urandom));
        end
    endtask

    task automatic drain_all();
        while (pending_inputs.size() > 0 || readings_due.size() > 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            kind <= '0;
            sample <= '0;
            rx_byte <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                meter_step(kind, sample, rx_byte);
                pending_inputs.delete(0);
            end
            if (!push || !full)
            begin
                if (pending_inputs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push <= 1'b1;
                    kind <= pending_inputs[0].kind;
                    sample <= pending_inputs[0].sample;
                    rx_byte <= pending_inputs[0].rx_byte;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (readings_due.size() == 0)
                    flag_mismatch("transaction with no result due", tx_byte, 0);
                else
                begin
                    next_due = readings_due.pop_front();
                    if (out_kind !== next_due.out_kind)
                        flag_mismatch("out_kind", out_kind, next_due.out_kind);
                    if (segments !== next_due.segments)
                        flag_mismatch("segments", segments, next_due.segments);
                    if (digit_enable !== next_due.digit_enable)
                        flag_mismatch("digit_enable", digit_enable, next_due.digit_enable);
                    if (tx_byte !== next_due.tx_byte)
                        flag_mismatch("tx_byte", tx_byte, next_due.tx_byte);
                    if (last !== next_due.last)
                        flag_mismatch("last", last, next_due.last);
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) ||
                (pending_inputs.size() == 0 && readings_due.size() == 0))
                stuck = 0;
            else
                stuck++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        gen_samples = 0;
        gen_level = 0;
        batch_sum = '0;
        batch_count = 0;
        volts_bcd = '0;
        lowest_bcd = vmd_pkg::MIN_BCD_RESET;
        highest_bcd = '0;
        showing_high = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_input(KIND_IGNORED, 10'd1023, 8'hFF);
        add_input(vmd_pkg::KIND_TICK, 10'd0, 8'h00);
        add_input(vmd_pkg::KIND_RX, 10'd0, vmd_pkg::CHAR_UPPER_M);
        add_input(vmd_pkg::KIND_RX, 10'd0, vmd_pkg::CHAR_LOWER_M);
        add_input(vmd_pkg::KIND_RX, 10'd1023, 8'h00);
        add_input(vmd_pkg::KIND_RX, 10'd0, 8'hFF);
        repeat (BATCH) add_input(vmd_pkg::KIND_SAMPLE, 10'd1023, 8'h00);
        add_input(vmd_pkg::KIND_TICK, 10'd1023, 8'hFF);
        add_input(vmd_pkg::KIND_TICK, 10'd0, 8'h00);
        repeat (BATCH) add_input(vmd_pkg::KIND_SAMPLE, 10'd0, 8'hFF);
        add_input(vmd_pkg::KIND_RX, 10'd0, vmd_pkg::CHAR_LOWER_M);
        add_input(vmd_pkg::KIND_RX, 10'd1023, vmd_pkg::CHAR_UPPER_M);
        drain_all();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 84;
                end
                default:
                begin
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase
            add_random_inputs(60);
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vmd_pkg.sv
hdl/vmd_fifo.sv
hdl/vmd_front.sv
hdl/vmd_back.sv
hdl/voltmeter_min_max_display_core.sv
tb/voltmeter_min_max_display_core_tb.sv
